/* design/rsa_block_modexp_defines.svh */
// assertion macros shared by the checkers of the modexp block
`ifndef RSA_BLOCK_MODEXP_DEFINES_SVH
`define RSA_BLOCK_MODEXP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define RBM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rbm: same-cycle property violated");

// next-cycle implication, disabled while reset is low
`define RBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rbm: next-cycle property violated");

`endif

/* design/rbm_pkg.sv */
`timescale 1ns / 1ps

package rbm_pkg;

	localparam int MOD_BITS     = 20;
	localparam int REG_BITS     = 20;
	localparam int CHAR_BITS    = 8;
	localparam int BLOCK_BASE   = 1000;
	localparam int CFG_IDX_BITS = 2;

	// bit counter of the serial multiplier
	localparam int STEP_BITS = $clog2(MOD_BITS);
	// quotient bits of a MOD_BITS value divided by the block base
	localparam int QUOT_BITS = MOD_BITS - $clog2(BLOCK_BASE) + 1;

	// reciprocal of the block base, scaled by 2**RECIP_SHIFT and rounded up;
	// exact over the whole MOD_BITS input range
	localparam int RECIP_SHIFT = MOD_BITS + $clog2(BLOCK_BASE);
	localparam int RECIP_BITS  = RECIP_SHIFT - $clog2(BLOCK_BASE) + 1;
	localparam longint RECIP_MUL =
		((longint'(1) << RECIP_SHIFT) + longint'(BLOCK_BASE) - 1) / longint'(BLOCK_BASE);

	typedef logic [MOD_BITS-1:0]     mod_word_t;
	typedef logic [REG_BITS-1:0]     reg_word_t;
	typedef logic [CHAR_BITS-1:0]    char_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	// register indexes
	localparam cfg_idx_t CFG_MODULUS  = CFG_IDX_BITS'(0);
	localparam cfg_idx_t CFG_PUB_EXP  = CFG_IDX_BITS'(1);
	localparam cfg_idx_t CFG_PRIV_EXP = CFG_IDX_BITS'(2);

	// mode codes
	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	// register reset values
	localparam mod_word_t RST_MODULUS  = MOD_BITS'(506503);
	localparam reg_word_t RST_PUB_EXP  = REG_BITS'(7);
	localparam reg_word_t RST_PRIV_EXP = REG_BITS'(216463);

endpackage

/* design/rsa_block_modexp.sv */
`timescale 1ns / 1ps

// textbook rsa on two-character blocks. an item is taken when start is high and busy is low;
// in encrypt mode the characters are packed as first*1000+second and raised to the public
// exponent, in decrypt mode cipher_in is raised to the private exponent, both modulo the
// configured modulus, and a decrypted value is split into quotient and remainder by 1000.
// the result shows for exactly one cycle with done high and cannot be held off by the
// receiver, so it must be captured on that edge. the exponentiation runs on one bit-serial
// modular multiplier that takes one multiplier bit per cycle; it first reduces the base
// modulo the modulus, then squares for each exponent bit and multiplies for each set one,
// and in decrypt mode the split by 1000 uses a reciprocal multiply. a modulus below two
// gives a result of zero.
// registers are written through the cfg channel, which is ready only while the block is
// idle; index 3 is ignored.
module rsa_block_modexp (
	input  logic                 clk,
	input  logic                 arst_n,
	// item channel
	input  logic                 start,
	output logic                 busy,
	input  logic                 mode,
	input  rbm_pkg::char_t       first_char,
	input  rbm_pkg::char_t       second_char,
	input  rbm_pkg::mod_word_t   cipher_in,
	// result
	output logic                 done,
	output rbm_pkg::mod_word_t   cipher_out,
	output rbm_pkg::char_t       plain_first,
	output rbm_pkg::char_t       plain_second,
	// register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  rbm_pkg::cfg_idx_t    cfg_index,
	input  rbm_pkg::reg_word_t   cfg_data
);
	import rbm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED,   // base modulo modulus
		S_BIT,   // pick the next exponent bit
		S_MUL,   // acc * sq
		S_SQR,   // sq * sq
		S_FIN,   // encrypt result, or quotient by the block base
		S_DIV    // remainder by the block base and the split result
	} state_t;

	state_t              state_q;

	// configuration registers
	mod_word_t           modulus_q;
	reg_word_t           pub_exp_q;
	reg_word_t           priv_exp_q;

	// working registers
	logic                mode_q;
	reg_word_t           exp_q;
	mod_word_t           acc_q;
	mod_word_t           sq_q;
	mod_word_t           prod_q;
	mod_word_t           mul_b_q;
	logic [STEP_BITS-1:0] step_q;
	mod_word_t           rem_q;
	logic [QUOT_BITS-1:0] quot_q;

	// result registers
	logic                done_q;
	mod_word_t           cipher_out_q;
	char_t               plain_first_q;
	char_t               plain_second_q;

	// shared multiplier datapath
	mod_word_t           mul_a;
	mod_word_t           addend;
	logic [MOD_BITS:0]   mod_ext;
	logic [MOD_BITS:0]   dbl;
	logic [MOD_BITS:0]   dbl_red;
	logic [MOD_BITS:0]   sum;
	logic [MOD_BITS:0]   sum_red;
	mod_word_t           mul_res;

	// split datapath
	logic [MOD_BITS+RECIP_BITS-1:0] recip_prod;
	logic [QUOT_BITS-1:0] quot_calc;
	mod_word_t           quot_back;
	mod_word_t           rem_calc;

	mod_word_t           pack_base;
	logic                mod_small;
	logic                last_step;

	assign busy         = (state_q != S_IDLE);
	assign cfg_ready    = (state_q == S_IDLE);
	assign done         = done_q;
	assign cipher_out   = cipher_out_q;
	assign plain_first  = plain_first_q;
	assign plain_second = plain_second_q;

	// two characters packed into one block value
	assign pack_base = mod_word_t'(first_char) * mod_word_t'(BLOCK_BASE)
		+ mod_word_t'(second_char);
	assign mod_small = (modulus_q[MOD_BITS-1:1] == '0);
	assign last_step = (step_q == '0);

	// interleaved modular multiply: prod = 2*prod + b_bit*a, reduced modulo the modulus
	always_comb begin
		case (state_q)
			S_RED:   mul_a = mod_word_t'(1);
			S_MUL:   mul_a = acc_q;
			default: mul_a = sq_q;
		endcase
		addend  = mul_b_q[MOD_BITS-1] ? mul_a : '0;
		mod_ext = {1'b0, modulus_q};
		dbl     = {prod_q, 1'b0};
		dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
		sum     = dbl_red + {1'b0, addend};
		sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
		mul_res = sum_red[MOD_BITS-1:0];
	end

	// quotient by the block base from a reciprocal multiply, remainder from the quotient
	always_comb begin
		recip_prod = (MOD_BITS + RECIP_BITS)'(acc_q) * (MOD_BITS + RECIP_BITS)'(RECIP_MUL);
		quot_calc  = recip_prod[RECIP_SHIFT +: QUOT_BITS];
		quot_back  = mod_word_t'(quot_q) * mod_word_t'(BLOCK_BASE);
		rem_calc   = rem_q - quot_back;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= RST_MODULUS;
			pub_exp_q  <= RST_PUB_EXP;
			priv_exp_q <= RST_PRIV_EXP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODULUS:  modulus_q  <= cfg_data[MOD_BITS-1:0];
				CFG_PUB_EXP:  pub_exp_q  <= cfg_data;
				CFG_PRIV_EXP: priv_exp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			mode_q         <= MODE_ENCRYPT;
			exp_q          <= '0;
			acc_q          <= '0;
			sq_q           <= '0;
			prod_q         <= '0;
			mul_b_q        <= '0;
			step_q         <= '0;
			rem_q          <= '0;
			quot_q         <= '0;
			done_q         <= 1'b0;
			cipher_out_q   <= '0;
			plain_first_q  <= '0;
			plain_second_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q  <= mode;
						exp_q   <= (mode == MODE_DECRYPT) ? priv_exp_q : pub_exp_q;
						mul_b_q <= (mode == MODE_DECRYPT) ? cipher_in : pack_base;
						prod_q  <= '0;
						step_q  <= STEP_BITS'(MOD_BITS - 1);
						if (mod_small) begin
							// every power is zero
							acc_q   <= '0;
							state_q <= S_FIN;
						end else begin
							acc_q   <= mod_word_t'(1);
							state_q <= S_RED;
						end
					end
				end
				S_RED: begin
					prod_q  <= mul_res;
					mul_b_q <= mul_b_q << 1;
					step_q  <= step_q - 1'b1;
					if (last_step) begin
						sq_q    <= mul_res;
						state_q <= S_BIT;
					end
				end
				S_BIT: begin
					prod_q  <= '0;
					step_q  <= STEP_BITS'(MOD_BITS - 1);
					mul_b_q <= sq_q;
					if (exp_q == '0) begin
						state_q <= S_FIN;
					end else if (exp_q[0]) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_SQR;
					end
				end
				S_MUL: begin
					prod_q  <= mul_res;
					mul_b_q <= mul_b_q << 1;
					step_q  <= step_q - 1'b1;
					if (last_step) begin
						acc_q   <= mul_res;
						prod_q  <= '0;
						step_q  <= STEP_BITS'(MOD_BITS - 1);
						mul_b_q <= sq_q;
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					prod_q  <= mul_res;
					mul_b_q <= mul_b_q << 1;
					step_q  <= step_q - 1'b1;
					if (last_step) begin
						sq_q    <= mul_res;
						exp_q   <= exp_q >> 1;
						state_q <= S_BIT;
					end
				end
				S_FIN: begin
					if (mode_q == MODE_DECRYPT) begin
						rem_q   <= acc_q;
						quot_q  <= quot_calc;
						state_q <= S_DIV;
					end else begin
						cipher_out_q   <= acc_q;
						plain_first_q  <= '0;
						plain_second_q <= '0;
						done_q         <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				S_DIV: begin
					cipher_out_q   <= '0;
					plain_first_q  <= quot_q[CHAR_BITS-1:0];
					plain_second_q <= rem_calc[CHAR_BITS-1:0];
					done_q         <= 1'b1;
					state_q        <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* design/rbm_checker.sv */
`timescale 1ns / 1ps
`include "rsa_block_modexp_defines.svh"

module rbm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input rbm_pkg::mod_word_t cipher_out,
	input rbm_pkg::char_t     plain_first,
	input rbm_pkg::char_t     plain_second
);
	import rbm_pkg::*;

	// an accepted item keeps the block busy
	`RBM_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// a result closes the work on its item
	`RBM_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy)
	`RBM_ASSERT_SAME(a_done_after_work, clk, arst_n, done, $past(busy))
	// the strobe lasts one cycle
	`RBM_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	// an encrypt result with a nonzero cipher_out carries no plaintext
	`RBM_ASSERT_SAME(a_one_mode, clk, arst_n, done && (cipher_out != '0), (plain_first == '0) && (plain_second == '0))

endmodule

bind rsa_block_modexp rbm_checker u_rbm_checker (.*);
